@@ rtl/sacov2_pkg.sv @@
// Shared constants, operation codes and helpers for the twice-covered area sweep core.
// No dependencies; used by sweep_area_covered_twice_core.
`default_nettype none

package sacov2_pkg;

    // Default tree size and cover count width
    localparam int LEAF_SLOTS_DEF = 2048;
    localparam int COUNT_BITS_DEF = 12;

    // Field widths
    localparam int LEN_W  = 32;
    localparam int AREA_W = 63;
    localparam int PROD_W = 64;

    localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};
    localparam logic [LEN_W-1:0]  LEN_MAX  = {LEN_W{1'b1}};

    // Operation codes
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_EVENT = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Saturating unsigned add of two lengths
    function automatic logic [LEN_W-1:0] sat_add32(input logic [LEN_W-1:0] a,
                                                    input logic [LEN_W-1:0] b);
        logic [LEN_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[LEN_W] ? LEN_MAX : s[LEN_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/sweep_area_covered_twice_core.sv @@
// Sweep-line segment tree for the area covered by at least two rectangles.
// Depends on sacov2_pkg (constants, operation codes, saturating add).
`default_nettype none

// One request at a time: start is taken when busy is low, and exactly one result
// follows on once_length/twice_length/area_total with done high for one cycle; the
// receiver cannot stall it. Node counts and lengths sit in synchronous memories with
// one read and one write port, walked by a depth-first sequencer with an explicit
// stack. A load or an unused code goes straight to the root read; an event first visits
// each tree node it touches (at most about 4*log2(LEAF_SLOTS) nodes), then reads the root
// and does the area multiply-accumulate; a clear zeroes the tree and then reads the root.
// After reset a clearing pass runs with busy high.
module sweep_area_covered_twice_core #(
    parameter int LEAF_SLOTS = sacov2_pkg::LEAF_SLOTS_DEF,
    parameter int COUNT_BITS = sacov2_pkg::COUNT_BITS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [1:0]          operation,
    input  wire logic [10:0]         coord_index,
    input  wire logic signed [31:0]  coord_value,
    input  wire logic [10:0]         lo_index,
    input  wire logic [11:0]         hi_index,
    input  wire logic signed [1:0]   cover_delta,
    input  wire logic [31:0]         strip_width,
    output logic                     done,
    output logic [31:0]              once_length,
    output logic [31:0]              twice_length,
    output logic [62:0]              area_total
);

    localparam int NODE_SLOTS = 4 * LEAF_SLOTS;
    localparam int NW         = $clog2(NODE_SLOTS);
    localparam int LEAF_W     = $clog2(LEAF_SLOTS);
    localparam int PW         = (LEAF_W + 1 > 13) ? LEAF_W + 1 : 13;
    localparam int STK_DEPTH  = 2 * (LEAF_W + 2);
    localparam int STI_W      = $clog2(STK_DEPTH);
    localparam int SPW        = $clog2(STK_DEPTH + 1);
    localparam int CW         = COUNT_BITS + 2;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [PW-1:0] LEAF_P  = PW'(LEAF_SLOTS);
    localparam logic [PW-1:0] LAST_P  = PW'(LEAF_SLOTS - 1);
    localparam logic [NW:0]   NODE_LIM = (NW + 1)'(NODE_SLOTS);
    localparam logic [NW-1:0] NODE_END = NW'(NODE_SLOTS - 1);
    localparam logic [NW-1:0] ROOT     = NW'(1);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_VISIT, S_CNTWR, S_RF1, S_RF2, S_RF3, S_RFWB,
        S_ROOT, S_ROOTD, S_MUL, S_ACC, S_OUT
    } state_t;

    state_t state_reg;
    logic [1:0]         op_reg;
    logic [PW-1:0]      l_reg, r_reg;
    logic signed [1:0]  d_reg;
    logic [31:0]        w_reg;
    logic [SPW-1:0]     sp_reg;
    logic [NW-1:0]      clr_reg;
    logic               init_reg;

    logic [NW-1:0]      stk_node_reg [STK_DEPTH];
    logic [PW-1:0]      stk_nl_reg   [STK_DEPTH];
    logic [PW-1:0]      stk_nr_reg   [STK_DEPTH];
    logic               stk_exp_reg  [STK_DEPTH];

    logic [COUNT_BITS-1:0] cnt_reg;
    logic signed [31:0] clo_reg, chi_reg;
    logic [31:0]        oa_reg, ta_reg;
    logic [31:0]        s_once_reg, s_twice_reg, s_all_reg, full_reg;
    logic [31:0]        root_once_reg, root_twice_reg;
    logic [63:0]        prod_reg;
    logic [62:0]        area_reg;
    logic [31:0]        once_out_reg, twice_out_reg;

    // Memories
    logic [COUNT_BITS-1:0] cnt_mem [NODE_SLOTS];
    logic [63:0]           lens_mem [NODE_SLOTS];
    logic [31:0]           coord_mem [LEAF_SLOTS];

    logic                  cnt_we, lens_we, coord_we;
    logic [NW-1:0]         cnt_waddr, cnt_raddr, lens_waddr, lens_raddr;
    logic [COUNT_BITS-1:0] cnt_wdata, cnt_rdata;
    logic [63:0]           lens_wdata, lens_rdata;
    logic [LEAF_W-1:0]     coord_waddr, coord_raddr;
    logic [31:0]           coord_rdata;

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        cnt_rdata <= cnt_mem[cnt_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (lens_we)
        begin
            lens_mem[lens_waddr] <= lens_wdata;
        end
        lens_rdata <= lens_mem[lens_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (coord_we)
        begin
            coord_mem[coord_waddr] <= coord_value;
        end
        coord_rdata <= coord_mem[coord_raddr];
    end

    // Stack top and child geometry
    logic [STI_W-1:0] tix, pix0, pix1;
    logic [NW-1:0]    top_node;
    logic [PW-1:0]    top_nl, top_nr, mid, hi_coord;
    logic             top_exp, covered, push_l, push_r, kids, last_pop, node_ok;
    logic [NW:0]      child_a, child_b;

    assign tix      = STI_W'(sp_reg - 1'b1);
    assign pix0     = STI_W'(sp_reg);
    assign pix1     = STI_W'(sp_reg + 1'b1);
    assign top_node = stk_node_reg[tix];
    assign top_nl   = stk_nl_reg[tix];
    assign top_nr   = stk_nr_reg[tix];
    assign top_exp  = stk_exp_reg[tix];
    assign covered  = (l_reg <= top_nl) && (top_nr <= r_reg);
    assign mid      = PW'((top_nl + top_nr) >> 1);
    assign push_l   = (l_reg <= mid);
    assign push_r   = (mid < r_reg);
    assign child_a  = {top_node, 1'b0};
    assign child_b  = {top_node, 1'b1};
    assign kids     = (top_nl != top_nr) && (child_b < NODE_LIM);
    assign hi_coord = (top_nr + 1'b1 >= LEAF_P) ? LAST_P : PW'(top_nr + 1'b1);
    assign last_pop = (sp_reg == SPW'(1));
    assign node_ok  = ({1'b0, top_node} < NODE_LIM);

    // Request decode in idle
    logic [PW-1:0] lo_ext, hi_ext, hi_clamp;
    logic          accept, range_ok;

    assign accept   = start && (state_reg == S_IDLE);
    assign lo_ext   = PW'(lo_index);
    assign hi_ext   = PW'(hi_index);
    assign hi_clamp = (hi_ext > LEAF_P) ? LEAF_P : hi_ext;
    assign range_ok = (hi_clamp > lo_ext);

    // Cover count update with saturation
    logic signed [CW-1:0] csum;
    logic [COUNT_BITS-1:0] cnt_next;

    assign csum = $signed({2'b00, cnt_rdata}) + CW'(d_reg);
    always_comb
    begin
        if (csum < 0)
            cnt_next = '0;
        else if (csum > $signed({2'b00, COUNT_MAX}))
            cnt_next = COUNT_MAX;
        else
            cnt_next = cnt_rdata;
        if (csum >= 0 && csum <= $signed({2'b00, COUNT_MAX}))
            cnt_next = csum[COUNT_BITS-1:0];
    end

    // Node length refresh
    logic signed [32:0] span;
    logic [31:0]        ob, tb, once_next, twice_next;

    assign span = {chi_reg[31], chi_reg} - {clo_reg[31], clo_reg};
    assign ob   = kids ? lens_rdata[63:32] : '0;
    assign tb   = kids ? lens_rdata[31:0]  : '0;

    always_comb
    begin
        once_next  = '0;
        twice_next = '0;
        if (cnt_reg >= COUNT_BITS'(2))
        begin
            twice_next = full_reg;
        end
        else if (cnt_reg == COUNT_BITS'(1))
        begin
            twice_next = s_all_reg;
            once_next  = (s_all_reg > full_reg) ? '0 : full_reg - s_all_reg;
        end
        else
        begin
            once_next  = s_once_reg;
            twice_next = s_twice_reg;
        end
    end

    // Area accumulate with saturation
    logic [64:0] area_sum;
    assign area_sum = {2'b00, area_reg} + {1'b0, prod_reg};

    // Memory port control
    always_comb
    begin
        cnt_we      = 1'b0;
        lens_we     = 1'b0;
        coord_we    = 1'b0;
        cnt_waddr   = top_node;
        cnt_wdata   = cnt_next;
        cnt_raddr   = top_node;
        lens_waddr  = top_node;
        lens_wdata  = {once_next, twice_next};
        lens_raddr  = child_a[NW-1:0];
        coord_waddr = LEAF_W'(coord_index);
        coord_raddr = top_nl[LEAF_W-1:0];
        case (state_reg)
            S_CLEAR:
            begin
                cnt_we     = 1'b1;
                lens_we    = 1'b1;
                cnt_waddr  = clr_reg;
                lens_waddr = clr_reg;
                cnt_wdata  = '0;
                lens_wdata = '0;
            end
            S_IDLE:
            begin
                coord_we = accept && (operation == sacov2_pkg::OP_LOAD)
                           && (PW'(coord_index) < LEAF_P);
            end
            S_CNTWR:
            begin
                cnt_we = 1'b1;
            end
            S_RF1:
            begin
                coord_raddr = hi_coord[LEAF_W-1:0];
            end
            S_RF2:
            begin
                lens_raddr = child_b[NW-1:0];
            end
            S_RFWB:
            begin
                lens_we = 1'b1;
            end
            S_ROOT:
            begin
                lens_raddr = ROOT;
            end
            default:
            begin
            end
        endcase
    end

    // Sequencer, stack and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            init_reg       <= 1'b1;
            clr_reg        <= '0;
            sp_reg         <= '0;
            op_reg         <= sacov2_pkg::OP_LOAD;
            area_reg       <= '0;
            once_out_reg   <= '0;
            twice_out_reg  <= '0;
            l_reg          <= '0;
            r_reg          <= '0;
            d_reg          <= '0;
            w_reg          <= '0;
            cnt_reg        <= '0;
            clo_reg        <= '0;
            chi_reg        <= '0;
            oa_reg         <= '0;
            ta_reg         <= '0;
            s_once_reg     <= '0;
            s_twice_reg    <= '0;
            s_all_reg      <= '0;
            full_reg       <= '0;
            root_once_reg  <= '0;
            root_twice_reg <= '0;
            prod_reg       <= '0;
            for (int i = 0; i < STK_DEPTH; i++)
            begin
                stk_node_reg[i] <= '0;
                stk_nl_reg[i]   <= '0;
                stk_nr_reg[i]   <= '0;
                stk_exp_reg[i]  <= 1'b0;
            end
        end
        else
        begin
            case (state_reg)
                // Sweep every node back to zero
                S_CLEAR:
                begin
                    if (clr_reg == NODE_END)
                    begin
                        clr_reg  <= '0;
                        init_reg <= 1'b0;
                        area_reg <= '0;
                        state_reg <= init_reg ? S_IDLE : S_ROOT;
                    end
                    else
                    begin
                        clr_reg <= clr_reg + 1'b1;
                    end
                end
                // Take a request
                S_IDLE:
                begin
                    if (start)
                    begin
                        op_reg <= operation;
                        l_reg  <= lo_ext;
                        r_reg  <= PW'(hi_clamp - 1'b1);
                        d_reg  <= cover_delta;
                        w_reg  <= strip_width;
                        if (operation == sacov2_pkg::OP_CLEAR)
                        begin
                            state_reg <= S_CLEAR;
                        end
                        else if (operation == sacov2_pkg::OP_EVENT && range_ok)
                        begin
                            stk_node_reg[0] <= ROOT;
                            stk_nl_reg[0]   <= '0;
                            stk_nr_reg[0]   <= LAST_P;
                            stk_exp_reg[0]  <= 1'b0;
                            sp_reg          <= SPW'(1);
                            state_reg       <= S_VISIT;
                        end
                        else
                        begin
                            state_reg <= S_ROOT;
                        end
                    end
                end
                // Decide on the node at the top of the stack
                S_VISIT:
                begin
                    if (!node_ok)
                    begin
                        sp_reg    <= sp_reg - 1'b1;
                        state_reg <= last_pop ? S_ROOT : S_VISIT;
                    end
                    else if (top_exp)
                    begin
                        state_reg <= S_RF1;
                    end
                    else if (covered)
                    begin
                        state_reg <= S_CNTWR;
                    end
                    else
                    begin
                        stk_exp_reg[tix] <= 1'b1;
                        if (push_r && push_l)
                        begin
                            stk_node_reg[pix0] <= child_b[NW-1:0];
                            stk_nl_reg[pix0]   <= PW'(mid + 1'b1);
                            stk_nr_reg[pix0]   <= top_nr;
                            stk_exp_reg[pix0]  <= 1'b0;
                            stk_node_reg[pix1] <= child_a[NW-1:0];
                            stk_nl_reg[pix1]   <= top_nl;
                            stk_nr_reg[pix1]   <= mid;
                            stk_exp_reg[pix1]  <= 1'b0;
                            sp_reg             <= SPW'(sp_reg + 2'd2);
                        end
                        else if (push_r)
                        begin
                            stk_node_reg[pix0] <= child_b[NW-1:0];
                            stk_nl_reg[pix0]   <= PW'(mid + 1'b1);
                            stk_nr_reg[pix0]   <= top_nr;
                            stk_exp_reg[pix0]  <= 1'b0;
                            sp_reg             <= sp_reg + 1'b1;
                        end
                        else if (push_l)
                        begin
                            stk_node_reg[pix0] <= child_a[NW-1:0];
                            stk_nl_reg[pix0]   <= top_nl;
                            stk_nr_reg[pix0]   <= mid;
                            stk_exp_reg[pix0]  <= 1'b0;
                            sp_reg             <= sp_reg + 1'b1;
                        end
                    end
                end
                // Write the adjusted cover count, then refresh the node
                S_CNTWR:
                begin
                    stk_exp_reg[tix] <= 1'b1;
                    state_reg        <= S_VISIT;
                end
                // Capture count and low coordinate
                S_RF1:
                begin
                    cnt_reg   <= cnt_rdata;
                    clo_reg   <= coord_rdata;
                    state_reg <= S_RF2;
                end
                // Capture high coordinate and left child lengths
                S_RF2:
                begin
                    chi_reg   <= coord_rdata;
                    oa_reg    <= kids ? lens_rdata[63:32] : '0;
                    ta_reg    <= kids ? lens_rdata[31:0]  : '0;
                    state_reg <= S_RF3;
                end
                // Combine child lengths and node span
                S_RF3:
                begin
                    s_once_reg  <= sacov2_pkg::sat_add32(oa_reg, ob);
                    s_twice_reg <= sacov2_pkg::sat_add32(ta_reg, tb);
                    s_all_reg   <= sacov2_pkg::sat_add32(
                                       sacov2_pkg::sat_add32(oa_reg, ta_reg),
                                       sacov2_pkg::sat_add32(ob, tb));
                    full_reg    <= span[32] ? '0 : span[31:0];
                    state_reg   <= S_RFWB;
                end
                // Write node lengths and pop
                S_RFWB:
                begin
                    sp_reg    <= sp_reg - 1'b1;
                    state_reg <= last_pop ? S_ROOT : S_VISIT;
                end
                S_ROOT:
                begin
                    state_reg <= S_ROOTD;
                end
                S_ROOTD:
                begin
                    root_once_reg  <= lens_rdata[63:32];
                    root_twice_reg <= lens_rdata[31:0];
                    state_reg <= (op_reg == sacov2_pkg::OP_EVENT) ? S_MUL : S_OUT;
                end
                S_MUL:
                begin
                    prod_reg  <= root_twice_reg * w_reg;
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    area_reg  <= (area_sum > {2'b00, sacov2_pkg::AREA_MAX})
                                 ? sacov2_pkg::AREA_MAX : area_sum[62:0];
                    state_reg <= S_OUT;
                end
                // Register the result on the output ports
                S_OUT:
                begin
                    once_out_reg  <= root_once_reg;
                    twice_out_reg <= root_twice_reg;
                    state_reg     <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Result ports
    logic done_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= (state_reg == S_OUT);
    end

    assign done         = done_reg;
    assign busy         = (state_reg != S_IDLE);
    assign once_length  = once_out_reg;
    assign twice_length = twice_out_reg;
    assign area_total   = area_reg;

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted without going busy");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");
    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SPW'(STK_DEPTH))
        else $error("traversal stack overflow");
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (sp_reg == '0))
        else $error("stack not empty when idle");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result given while still busy");
`endif

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// Testbench for sweep_area_covered_twice_core: random and directed sweep requests,
// checked against an in-bench segment tree. Depends on sacov2_pkg and the core RTL.
`timescale 1ns / 100ps

module testbench;

    localparam int LEAVES = 2048;
    localparam int NODES = 4 * LEAVES;
    // Coordinate slots that get loaded: a dense head, a dense tail and a grid between
    localparam int GRID = 16;
    localparam int DENSE_HEAD = 128;
    localparam int DENSE_TAIL = LEAVES - GRID;
    localparam int RANDOM_REQS = 465;
    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam logic [1:0] D_PLUS = 2'b01;
    localparam logic [1:0] D_MINUS = 2'b11;
    localparam logic [1:0] D_MINUS2 = 2'b10;
    localparam logic [1:0] D_ZERO = 2'b00;
    localparam longint CYCLE_LIMIT = 4_000_000;
    localparam int TAIL_CYCLES = 60;

    typedef struct {
        logic [1:0]  op;
        logic [10:0] cidx;
        logic [31:0] cval;
        logic [10:0] lo;
        logic [11:0] hi;
        logic [1:0]  dl;
        logic [31:0] w;
        bit          drain;
    } sweep_req_t;

    typedef struct {
        logic [31:0] once;
        logic [31:0] twice;
        logic [62:0] area;
    } sweep_sums_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic [1:0] operation = '0;
    logic [10:0] coord_index = '0;
    logic signed [31:0] coord_value = '0;
    logic [10:0] lo_index = '0;
    logic [11:0] hi_index = '0;
    logic signed [1:0] cover_delta = '0;
    logic [31:0] strip_width = '0;
    logic busy, done;
    logic [31:0] once_length, twice_length;
    logic [62:0] area_total;

    sweep_req_t sweep_requests[$];
    sweep_sums_t expected_sums[$];
    int errors = 0;
    longint cycles = 0;

    // Shadow tree
    logic [31:0] y_table[LEAVES];
    int unsigned cover_cnt[NODES];
    logic [31:0] once_len[NODES];
    logic [31:0] twice_len[NODES];
    logic [63:0] area_acc;

    sweep_area_covered_twice_core dut (
        .clk, .rst_n, .start, .busy, .operation, .coord_index, .coord_value,
        .lo_index, .hi_index, .cover_delta, .strip_width, .done,
        .once_length, .twice_length, .area_total
    );

    always #10 clk = ~clk;

    function automatic longint y_at(int unsigned i);
        if (i >= LEAVES) i = LEAVES - 1;
        return longint'($signed(y_table[i]));
    endfunction

    function automatic logic [31:0] len_add(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // Recompute once/twice lengths of one node from its count and children
    function automatic void node_update(int unsigned node, int unsigned nl, int unsigned nr);
        longint span;
        logic [31:0] full, once, twice;
        int unsigned a, b;
        bit inner;
        span = y_at(nr + 1) - y_at(nl);
        a = 2 * node;
        b = 2 * node + 1;
        inner = (nl != nr) && (b < NODES);
        once = '0;
        twice = '0;
        if (span < 0) span = 0;
        if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
        full = span[31:0];
        if (cover_cnt[node] >= 2)
        begin
            twice = full;
        end
        else if (cover_cnt[node] == 1)
        begin
            if (inner)
                twice = len_add(len_add(once_len[a], twice_len[a]),
                                len_add(once_len[b], twice_len[b]));
            once = (twice > full) ? '0 : full - twice;
        end
        else if (inner)
        begin
            once = len_add(once_len[a], once_len[b]);
            twice = len_add(twice_len[a], twice_len[b]);
        end
        once_len[node] = once;
        twice_len[node] = twice;
    endfunction

    function automatic void cover_range(int unsigned node, int unsigned nl, int unsigned nr,
                                        int unsigned l, int unsigned r, int d);
        int c;
        int unsigned m;
        if (node >= NODES) return;
        if (l <= nl && nr <= r)
        begin
            c = int'(cover_cnt[node]) + d;
            if (c < 0) c = 0;
            if (c > 4095) c = 4095;
            cover_cnt[node] = unsigned'(c);
        end
        else
        begin
            m = (nl + nr) >> 1;
            if (l <= m) cover_range(2 * node, nl, m, l, r, d);
            if (m < r) cover_range(2 * node + 1, m + 1, nr, l, r, d);
        end
        node_update(node, nl, nr);
    endfunction

    function automatic void tree_clear();
        for (int i = 0; i < NODES; i++)
        begin
            cover_cnt[i] = 0;
            once_len[i] = '0;
            twice_len[i] = '0;
        end
        area_acc = '0;
    endfunction

    // Apply one accepted request to the shadow tree and queue its sums
    function automatic void sweep_apply(sweep_req_t q);
        int unsigned hi;
        int d;
        logic [63:0] prod, sum;
        sweep_sums_t s;
        case (q.op)
            sacov2_pkg::OP_LOAD:
            begin
                y_table[q.cidx] = q.cval;
            end
            sacov2_pkg::OP_EVENT:
            begin
                hi = 32'(q.hi);
                d = int'($signed(q.dl));
                if (hi > LEAVES) hi = LEAVES;
                if (hi > q.lo) cover_range(1, 0, LEAVES - 1, 32'(q.lo), hi - 1, d);
                prod = 64'(twice_len[1]) * 64'(q.w);
                sum = area_acc + prod;
                if (sum < prod || sum > 64'(sacov2_pkg::AREA_MAX))
                    sum = 64'(sacov2_pkg::AREA_MAX);
                area_acc = sum;
            end
            sacov2_pkg::OP_CLEAR:
            begin
                tree_clear();
            end
            default:
            begin
            end
        endcase
        s.once = once_len[1];
        s.twice = twice_len[1];
        s.area = area_acc[62:0];
        expected_sums.insert(expected_sums.size(), s);
    endfunction

    function automatic sweep_req_t mk_req(logic [1:0] op);
        sweep_req_t q;
        q.op = op;
        q.cidx = 11'($urandom);
        q.cval = $urandom;
        q.lo = 11'($urandom);
        q.hi = 12'($urandom);
        q.dl = 2'($urandom);
        q.w = $urandom;
        q.drain = 1'b0;
        return q;
    endfunction

    function automatic void add_req(sweep_req_t q);
        sweep_requests.insert(sweep_requests.size(), q);
    endfunction

    function automatic void add_event(int lo, int hi, logic [1:0] dl, logic [31:0] w);
        sweep_req_t q;
        q = mk_req(sacov2_pkg::OP_EVENT);
        q.lo = 11'(lo);
        q.hi = 12'(hi);
        q.dl = dl;
        q.w = w;
        add_req(q);
    endfunction

    function automatic void add_load(int idx, logic [31:0] v);
        sweep_req_t q;
        q = mk_req(sacov2_pkg::OP_LOAD);
        q.cidx = 11'(idx);
        q.cval = v;
        add_req(q);
    endfunction

    function automatic void add_drain();
        sweep_req_t q;
        q = mk_req(OP_SPARE);
        q.drain = 1'b1;
        add_req(q);
    endfunction

    // Pick a range edge whose tree boundaries only touch loaded slots
    function automatic int pick_edge();
        int e;
        case ($urandom_range(3))
            0:
            begin
                e = int'($urandom_range(DENSE_HEAD));
            end
            1:
            begin
                e = int'($urandom_range(LEAVES, DENSE_TAIL));
            end
            default:
            begin
                e = GRID * int'($urandom_range(LEAVES / GRID));
            end
        endcase
        return e;
    endfunction

    // Driver: bursts of requests with random gaps
    int burst_left = 1;
    int gap_left = 0;
    always @(posedge clk)
    begin
        bit taken;
        sweep_req_t q;
        if (rst_n)
        begin
            taken = start && !busy;
            if (taken) sweep_apply('{operation, coord_index, coord_value, lo_index,
                                     hi_index, cover_delta, strip_width, 1'b0});
            if (!start || taken)
            begin
                // hold off while a pause marker waits for all sums to come back
                while (sweep_requests.size() > 0 && sweep_requests[0].drain
                       && expected_sums.size() == 0 && !taken)
                    void'(sweep_requests.pop_front());
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (sweep_requests.size() == 0 || sweep_requests[0].drain)
                begin
                    start <= 1'b0;
                end
                else
                begin
                    q = sweep_requests.pop_front();
                    operation <= q.op;
                    coord_index <= q.cidx;
                    coord_value <= q.cval;
                    lo_index <= q.lo;
                    hi_index <= q.hi;
                    cover_delta <= q.dl;
                    strip_width <= q.w;
                    start <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = int'($urandom_range(1, 20));
                        gap_left = ($urandom_range(3) == 0) ? 0 :
                                   ($urandom_range(7) == 0) ? int'($urandom_range(60)) :
                                                              int'($urandom_range(6));
                    end
                end
            end
        end
    end

    // Monitor: compare each result against the oldest expected sums
    always @(posedge clk)
    begin
        sweep_sums_t s;
        if (rst_n && done)
        begin
            if (expected_sums.size() == 0)
            begin
                $display("%0t: unexpected result once=%h twice=%h area=%h",
                         $realtime, once_length, twice_length, area_total);
                errors++;
            end
            else
            begin
                s = expected_sums.pop_front();
                if (once_length !== s.once)
                begin
                    $display("%0t: once_length exp %h got %h", $realtime, s.once, once_length);
                    errors++;
                end
                if (twice_length !== s.twice)
                begin
                    $display("%0t: twice_length exp %h got %h", $realtime, s.twice,
                             twice_length);
                    errors++;
                end
                if (area_total !== s.area)
                begin
                    $display("%0t: area_total exp %h got %h", $realtime, s.area, area_total);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[sweep_area_covered_twice_core] ERROR");
            $finish;
        end
    end

    initial
    begin
        int live_lo[$];
        int live_hi[$];
        int r, lo, hi, k;
        logic [31:0] y;
        tree_clear();

        // Load sorted coordinates into every slot that a range edge can reach
        y = 32'h8000_0000;
        for (int i = 0; i < LEAVES; i++)
        begin
            if (i < DENSE_HEAD || i >= DENSE_TAIL || i % GRID == 0)
            begin
                if (i == LEAVES - 1) y = 32'h7FFF_FFFF;
                else if (i > 0) y = y + $urandom_range(1, 1 << 22);
                add_load(i, y);
            end
        end

        // Directed: full range, saturation, empty ranges, odd deltas, clears
        add_event(0, 2048, D_PLUS, 32'd0);
        add_event(0, 2048, D_PLUS, 32'hFFFF_FFFF);
        add_event(10, 20, D_PLUS, 32'd1);
        add_event(0, 2048, D_MINUS, 32'd256);
        add_event(0, 2048, D_MINUS2, 32'd3);
        add_event(0, 2048, D_MINUS, 32'd5);
        add_event(9, 5, D_PLUS, 32'd100);
        add_event(7, 7, D_PLUS, 32'd100);
        add_event(1008, 4095, D_PLUS, 32'd77);
        add_event(2047, 2048, D_PLUS, 32'd9);
        add_event(2047, 2048, D_PLUS, 32'd9);
        add_event(3, 304, D_ZERO, 32'd11);
        add_req(mk_req(OP_SPARE));
        add_load(5, 32'h7FFF_0000);
        add_event(0, 64, D_PLUS, 32'd40);
        add_event(0, 64, D_PLUS, 32'd40);
        add_load(5, 32'h8000_0000 + 32'd5 * 32'd1000);
        add_drain();
        add_req(mk_req(sacov2_pkg::OP_CLEAR));
        add_event(100, 2000, D_PLUS, 32'd1);
        add_load(2047, 32'h7FFF_FFFF);
        add_req(mk_req(sacov2_pkg::OP_CLEAR));

        // Random: mostly rectangles entering and leaving, plus noise
        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            r = int'($urandom_range(99));
            if (r < 65)
            begin
                if (live_lo.size() > 0 && ($urandom_range(2) == 0 || live_lo.size() > 12))
                begin
                    k = int'($urandom_range(live_lo.size() - 1));
                    add_event(live_lo[k], live_hi[k],
                              ($urandom_range(9) == 0) ? D_MINUS2 : D_MINUS,
                              ($urandom_range(4) == 0) ? $urandom : $urandom_range(4096));
                    live_lo.delete(k);
                    live_hi.delete(k);
                end
                else
                begin
                    lo = pick_edge();
                    hi = pick_edge();
                    if (lo > hi)
                    begin
                        k = lo;
                        lo = hi;
                        hi = k;
                    end
                    if (lo >= LEAVES) lo = DENSE_TAIL;
                    if (hi == lo) hi = lo + GRID;
                    add_event(lo, hi, D_PLUS,
                              ($urandom_range(4) == 0) ? $urandom : $urandom_range(4096));
                    live_lo.insert(live_lo.size(), lo);
                    live_hi.insert(live_hi.size(), hi);
                end
            end
            else if (r < 77)
            begin
                lo = pick_edge();
                if (lo >= LEAVES) lo = 0;
                hi = pick_edge();
                if (hi == LEAVES) hi = hi + int'($urandom_range(LEAVES - 1));
                add_event(lo, hi, 2'($urandom), $urandom);
            end
            else if (r < 87)
            begin
                add_req(mk_req(sacov2_pkg::OP_LOAD));
            end
            else if (r < 93)
            begin
                add_req(mk_req(OP_SPARE));
            end
            else if (r < 95)
            begin
                add_req(mk_req(sacov2_pkg::OP_CLEAR));
                live_lo.delete();
                live_hi.delete();
            end
            else if (r < 96)
            begin
                add_drain();
            end
            else
            begin
                lo = pick_edge();
                if (lo >= LEAVES) lo = 0;
                add_event(lo, pick_edge(), D_PLUS, $urandom);
            end
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Drain and settle
        do @(posedge clk);
        while (sweep_requests.size() != 0 || start || expected_sums.size() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("[sweep_area_covered_twice_core] OK");
        else
            $display("[sweep_area_covered_twice_core] ERROR");
        $finish;
    end

endmodule
